>>> design/psched_pkg.sv
// Shared types and constants for the preemptive priority scheduler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package psched_pkg;

    localparam int QUEUE_DEPTH_DEF   = 16;
    localparam int ID_BITS_DEF       = 16;
    localparam int PRIORITY_BITS_DEF = 8;

    // Widths of the item fields on the ports
    localparam int OP_W       = 2;
    localparam int PRIO_FIELD = 8;
    localparam int ID_FIELD   = 16;
    localparam int COUNT_W    = 5;

    // Widest internal id and priority, used to extend fields safely
    localparam int ID_MAX_W   = 32;
    localparam int PRIO_MAX_W = 16;

    typedef enum logic [OP_W-1:0] {
        OP_NEW    = 2'd0,
        OP_FORK   = 2'd1,
        OP_RETURN = 2'd2,
        OP_YIELD  = 2'd3
    } t_op;

    typedef struct packed {
        t_op                   op;
        logic [PRIO_FIELD-1:0] priority_req;
        logic [ID_FIELD-1:0]   task_id;
    } t_sched_in;

    typedef struct packed {
        logic [ID_FIELD-1:0] running_id;
        logic                accepted;
        logic [COUNT_W-1:0]  queue_count;
    } t_sched_out;

    // Per-cycle command to every queue cell
    typedef struct packed {
        logic ins;
        logic pop;
    } t_cell_ctl;

endpackage

`default_nettype wire

>>> design/psched_cell.sv
// One slot of the sorted ready queue: holds an id and priority and shifts
// toward its neighbors on insert or pop. Depends on psched_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psched_cell
    import psched_pkg::*;
#(
    parameter int ID_BITS   = ID_BITS_DEF,
    parameter int PRIO_BITS = PRIORITY_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire t_cell_ctl            i_ctl,
    input  wire logic                 i_occ,
    input  wire logic                 i_keep,
    input  wire logic [ID_BITS-1:0]   i_new_id,
    input  wire logic [PRIO_BITS-1:0] i_new_prio,
    input  wire logic [ID_BITS-1:0]   i_left_id,
    input  wire logic [PRIO_BITS-1:0] i_left_prio,
    input  wire logic [ID_BITS-1:0]   i_right_id,
    input  wire logic [PRIO_BITS-1:0] i_right_prio,
    output logic                      o_keep,
    output logic [ID_BITS-1:0]        o_id,
    output logic [PRIO_BITS-1:0]      o_prio
);

    logic [ID_BITS-1:0]   r_id;
    logic [PRIO_BITS-1:0] r_prio;
    logic [ID_BITS-1:0]   n_id;
    logic [PRIO_BITS-1:0] n_prio;

    // Entry stays put when it is at least as urgent (equal priority stays ahead)
    assign o_keep = i_occ && (r_prio >= i_new_prio);

    always_comb begin
        n_id   = r_id;
        n_prio = r_prio;
        if (i_ctl.ins && !o_keep) begin
            if (i_keep) begin
                n_id   = i_new_id;
                n_prio = i_new_prio;
            end else begin
                n_id   = i_left_id;
                n_prio = i_left_prio;
            end
        end else if (i_ctl.pop) begin
            n_id   = i_right_id;
            n_prio = i_right_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id   <= n_id;
        r_prio <= n_prio;
    end

    assign o_id   = r_id;
    assign o_prio = r_prio;

endmodule

`default_nettype wire

>>> design/preemptive_priority_scheduler_core.sv
// Top level of the preemptive priority scheduler: running task, id counter,
// and a row of psched_cell slots forming the ready queue. Depends on psched_pkg.
`timescale 1ns / 1ps
`default_nettype none

// An item accepted at one edge (i_start high,
// o_busy low) has its result on o_result with o_done high for the following
// cycle. o_busy is high only during reset and the first cycle after it, so
// a new item may be issued in every cycle. Insert and pop are done by the
// cell row, each slot comparing its own priority with the
// incoming one and shifting toward its neighbor. Results cannot be stalled.
module preemptive_priority_scheduler_core
    import psched_pkg::*;
#(
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
    parameter int ID_BITS       = ID_BITS_DEF,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire t_sched_in  i_item,
    output logic            o_busy,
    output logic            o_done,
    output t_sched_out      o_result
);

    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    logic                     r_busy;
    logic                     r_done;
    t_sched_out               r_result;
    logic [ID_BITS-1:0]       r_run_id;
    logic [PRIORITY_BITS-1:0] r_run_prio;
    logic [FILL_W-1:0]        r_fill;
    logic [ID_BITS-1:0]       r_last;

    logic [ID_BITS-1:0]       n_run_id;
    logic [PRIORITY_BITS-1:0] n_run_prio;
    logic [FILL_W-1:0]        n_fill;
    logic [ID_BITS-1:0]       n_last;
    t_sched_out               n_result;

    logic                     w_go;
    logic [ID_MAX_W-1:0]      w_tid_ext;
    logic [PRIO_MAX_W-1:0]    w_prio_ext;
    logic [ID_BITS-1:0]       w_tid;
    logic [PRIORITY_BITS-1:0] w_req_prio;
    logic [ID_BITS-1:0]       w_issue;
    logic [ID_BITS-1:0]       w_arr_id;
    logic [PRIORITY_BITS-1:0] w_arr_prio;
    logic [ID_BITS-1:0]       w_enq_id;
    logic [PRIORITY_BITS-1:0] w_enq_prio;
    logic                     w_ok;
    logic                     w_idle;
    logic                     w_full;
    t_cell_ctl                w_ctl;
    logic [ID_MAX_W-1:0]      w_run_ext;
    logic [ID_MAX_W-1:0]      w_fill_ext;

    logic [ID_BITS-1:0]       w_cid   [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] w_cprio [QUEUE_DEPTH];
    logic                     w_keep  [QUEUE_DEPTH+1];

    assign w_go       = i_start && !r_busy;
    assign w_tid_ext  = ID_MAX_W'(i_item.task_id);
    assign w_prio_ext = PRIO_MAX_W'(i_item.priority_req);
    assign w_tid      = w_tid_ext[ID_BITS-1:0];
    assign w_req_prio = w_prio_ext[PRIORITY_BITS-1:0];

    // Ids count up and skip zero, which marks the idle CPU
    always_comb begin
        w_issue = r_last + ID_BITS'(1);
        if (w_issue == '0) begin
            w_issue = ID_BITS'(1);
        end
    end

    assign w_arr_id   = (i_item.op == OP_RETURN) ? w_tid : w_issue;
    assign w_arr_prio = (i_item.op == OP_FORK) ? r_run_prio : w_req_prio;
    assign w_idle     = (r_run_id == '0);
    assign w_full     = (r_fill >= FILL_W'(QUEUE_DEPTH));

    always_comb begin
        n_run_id   = r_run_id;
        n_run_prio = r_run_prio;
        n_fill     = r_fill;
        n_last     = r_last;
        w_ok       = 1'b1;
        w_ctl      = '0;
        w_enq_id   = w_arr_id;
        w_enq_prio = w_arr_prio;
        if (w_go) begin
            case (i_item.op)
                OP_YIELD: begin
                    if (r_fill != '0) begin
                        n_run_id   = w_cid[0];
                        n_run_prio = w_cprio[0];
                        n_fill     = r_fill - FILL_W'(1);
                        w_ctl.pop  = 1'b1;
                    end else begin
                        n_run_id   = '0;
                        n_run_prio = '0;
                    end
                end
                OP_NEW, OP_FORK, OP_RETURN: begin
                    if (i_item.op == OP_RETURN && w_tid == '0) begin
                        w_ok = 1'b0;
                    end else if (w_idle) begin
                        n_run_id   = w_arr_id;
                        n_run_prio = w_arr_prio;
                    end else if (w_full) begin
                        w_ok = 1'b0;
                    end else begin
                        // Preempt: the displaced task goes back in the queue
                        if (w_arr_prio > r_run_prio) begin
                            w_enq_id   = r_run_id;
                            w_enq_prio = r_run_prio;
                            n_run_id   = w_arr_id;
                            n_run_prio = w_arr_prio;
                        end
                        w_ctl.ins = 1'b1;
                        n_fill    = r_fill + FILL_W'(1);
                    end
                    if (w_ok && i_item.op != OP_RETURN) begin
                        n_last = w_issue;
                    end
                end
                default: begin
                    w_ok = 1'b0;
                end
            endcase
        end
    end

    assign w_run_ext  = ID_MAX_W'(n_run_id);
    assign w_fill_ext = ID_MAX_W'(n_fill);

    always_comb begin
        n_result.running_id  = w_run_ext[ID_FIELD-1:0];
        n_result.accepted    = w_ok;
        n_result.queue_count = w_fill_ext[COUNT_W-1:0];
    end

    assign w_keep[0] = 1'b1;

    for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
        logic [ID_BITS-1:0]       w_lid;
        logic [PRIORITY_BITS-1:0] w_lprio;
        logic [ID_BITS-1:0]       w_rid;
        logic [PRIORITY_BITS-1:0] w_rprio;

        if (k == 0) begin : g_head
            assign w_lid   = w_enq_id;
            assign w_lprio = w_enq_prio;
        end else begin : g_body
            assign w_lid   = w_cid[k-1];
            assign w_lprio = w_cprio[k-1];
        end

        if (k == QUEUE_DEPTH - 1) begin : g_tail
            assign w_rid   = w_cid[k];
            assign w_rprio = w_cprio[k];
        end else begin : g_mid
            assign w_rid   = w_cid[k+1];
            assign w_rprio = w_cprio[k+1];
        end

        psched_cell #(
            .ID_BITS   (ID_BITS),
            .PRIO_BITS (PRIORITY_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_occ        (r_fill > FILL_W'(k)),
            .i_keep       (w_keep[k]),
            .i_new_id     (w_enq_id),
            .i_new_prio   (w_enq_prio),
            .i_left_id    (w_lid),
            .i_left_prio  (w_lprio),
            .i_right_id   (w_rid),
            .i_right_prio (w_rprio),
            .o_keep       (w_keep[k+1]),
            .o_id         (w_cid[k]),
            .o_prio       (w_cprio[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_done     <= 1'b0;
            r_run_id   <= '0;
            r_run_prio <= '0;
            r_fill     <= '0;
            r_last     <= '0;
        end else begin
            r_busy     <= 1'b0;
            r_done     <= w_go;
            r_run_id   <= n_run_id;
            r_run_prio <= n_run_prio;
            r_fill     <= n_fill;
            r_last     <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_result <= n_result;
        end
    end

    assign o_busy   = r_busy;
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

>>> design/psched_checker.sv
// Port-level checks for the scheduler core, attached by bind.
// Depends on psched_pkg and preemptive_priority_scheduler_core.
`timescale 1ns / 1ps
`default_nettype none

module psched_checker
    import psched_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_start,
    input wire t_sched_in  i_item,
    input wire logic       o_busy,
    input wire logic       o_done,
    input wire t_sched_out o_result
);

    // Each accepted item yields exactly one result, in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_done)
        else $error("accepted item produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy))
        else $error("result without accepted item");

    // A yield is never refused
    a_yield_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_item.op) == OP_YIELD) |-> o_result.accepted)
        else $error("yield refused");

    // Idle CPU implies an empty ready queue
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.running_id == '0) |-> (o_result.queue_count == '0))
        else $error("CPU idle while tasks are queued");

endmodule

bind preemptive_priority_scheduler_core psched_checker u_psched_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .i_item   (i_item),
    .o_busy   (o_busy),
    .o_done   (o_done),
    .o_result (o_result)
);

`default_nettype wire

>>> tb/sched_event_checker.sv
// Checker for the preemptive priority scheduler: keeps its own copy of the
// CPU slot and the ready queue, predicts each result and compares it.
// Depends on psched_pkg.
`timescale 1ns / 1ps

module sched_event_checker
    import psched_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire logic       i_busy,
    input  wire logic       i_done,
    input  wire t_sched_in  i_item,
    input  wire t_sched_out i_result,
    output int              o_fail_count,
    output int              o_pending
);

    localparam int DEPTH = QUEUE_DEPTH_DEF;

    logic [ID_FIELD-1:0]   cpu_task;
    logic [PRIO_FIELD-1:0] cpu_prio;
    logic [ID_FIELD-1:0]   id_counter;
    logic [ID_FIELD-1:0]   ready_ids   [DEPTH];
    logic [PRIO_FIELD-1:0] ready_prios [DEPTH];
    int                    ready_len;

    t_sched_out outcomes_due[$];
    t_sched_out want;

    // Goes behind every entry of equal or higher priority, so ties stay FIFO.
    function automatic void ready_insert(input logic [ID_FIELD-1:0] id,
                                         input logic [PRIO_FIELD-1:0] prio);
        int pos;
        int k;
        pos = 0;
        while (pos < ready_len && ready_prios[pos] >= prio)
            pos++;
        for (k = ready_len; k > pos; k--) begin
            ready_ids[k]   = ready_ids[k-1];
            ready_prios[k] = ready_prios[k-1];
        end
        ready_ids[pos]   = id;
        ready_prios[pos] = prio;
        ready_len++;
    endfunction

    function automatic void ready_pop();
        int k;
        if (ready_len == 0) begin
            cpu_task = '0;
            cpu_prio = '0;
        end else begin
            cpu_task = ready_ids[0];
            cpu_prio = ready_prios[0];
            for (k = 1; k < ready_len; k++) begin
                ready_ids[k-1]   = ready_ids[k];
                ready_prios[k-1] = ready_prios[k];
            end
            ready_len--;
        end
    endfunction

    // Arriving task: idle CPU takes it, else preempt on strictly higher prio.
    function automatic bit place_task(input logic [ID_FIELD-1:0] id,
                                      input logic [PRIO_FIELD-1:0] prio);
        if (cpu_task == '0) begin
            cpu_task = id;
            cpu_prio = prio;
            return 1'b1;
        end
        if (ready_len >= DEPTH)
            return 1'b0;
        if (prio > cpu_prio) begin
            ready_insert(cpu_task, cpu_prio);
            cpu_task = id;
            cpu_prio = prio;
        end else begin
            ready_insert(id, prio);
        end
        return 1'b1;
    endfunction

    function automatic void schedule_event(input t_sched_in ev);
        logic [ID_FIELD-1:0]   next_id;
        logic [PRIO_FIELD-1:0] prio;
        bit                    ok;
        t_sched_out            res;
        ok = 1'b1;
        case (ev.op)
            OP_NEW, OP_FORK: begin
                next_id = id_counter + 1'b1;
                if (next_id == '0)
                    next_id = ID_FIELD'(1);
                prio = (ev.op == OP_FORK) ? cpu_prio : ev.priority_req;
                ok = place_task(next_id, prio);
                if (ok)
                    id_counter = next_id;
            end
            OP_RETURN: begin
                if (ev.task_id == '0)
                    ok = 1'b0;
                else
                    ok = place_task(ev.task_id, ev.priority_req);
            end
            default: ready_pop();
        endcase
        res.running_id  = cpu_task;
        res.accepted    = ok;
        res.queue_count = ready_len[COUNT_W-1:0];
        outcomes_due.insert(outcomes_due.size(), res);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cpu_task     = '0;
            cpu_prio     = '0;
            id_counter   = '0;
            ready_len    = 0;
            o_fail_count = 0;
            outcomes_due.delete();
        end else begin
            // check first: a result and a new item can share an edge
            if (i_done) begin
                if (outcomes_due.size() == 0) begin
                    $display("%0t: unexpected result running_id=%0d accepted=%0d count=%0d",
                             $time, i_result.running_id, i_result.accepted,
                             i_result.queue_count);
                    o_fail_count++;
                end else begin
                    want = outcomes_due.pop_front();
                    if (i_result.running_id !== want.running_id) begin
                        $display("%0t: running_id expected %0d got %0d",
                                 $time, want.running_id, i_result.running_id);
                        o_fail_count++;
                    end
                    if (i_result.accepted !== want.accepted) begin
                        $display("%0t: accepted expected %0d got %0d",
                                 $time, want.accepted, i_result.accepted);
                        o_fail_count++;
                    end
                    if (i_result.queue_count !== want.queue_count) begin
                        $display("%0t: queue_count expected %0d got %0d",
                                 $time, want.queue_count, i_result.queue_count);
                        o_fail_count++;
                    end
                end
            end
            if (i_start && !i_busy)
                schedule_event(i_item);
        end
        o_pending = outcomes_due.size();
    end

endmodule

>>> tb/preemptive_priority_scheduler_core_tb.sv
// Top of the scheduler testbench: clock, reset, directed and random events
// and verdict. Depends on psched_pkg, sched_event_checker and
// preemptive_priority_scheduler_core.
`timescale 1ns / 1ps

module preemptive_priority_scheduler_core_tb;
    import psched_pkg::*;

    localparam int STALL_LIMIT = 400;
    localparam int PHASE_ITEMS = 590;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_start = 1'b0;
    t_sched_in  i_item  = '0;
    logic       o_busy;
    logic       o_done;
    t_sched_out o_result;

    int fail_count;
    int pending;
    int idle_cycles = 0;

    always #5 i_clk = ~i_clk;

    preemptive_priority_scheduler_core u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_item   (i_item),
        .o_busy   (o_busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    sched_event_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_busy       (o_busy),
        .i_done       (o_done),
        .i_item       (i_item),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Watchdog: cycles with neither an item taken nor a result out
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_done) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("preemptive_priority_scheduler_core_tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_sched_in mk_event(input t_op op, input logic [7:0] prio,
                                           input logic [15:0] id);
        t_sched_in ev;
        ev.op           = op;
        ev.priority_req = prio;
        ev.task_id      = id;
        return ev;
    endfunction

    // Segments of 50 alternate between filling, draining and balanced mixes
    // so the queue spends real time both full and empty.
    function automatic t_sched_in rand_event(input int n);
        int           yield_pct;
        int           roll;
        t_op          op;
        logic [7:0]   prio;
        logic [15:0]  id;
        case ((n / 50) % 3)
            0:       yield_pct = 10;
            1:       yield_pct = 55;
            default: yield_pct = 30;
        endcase
        roll = $urandom_range(0, 99);
        if (roll < yield_pct)
            op = OP_YIELD;
        else if (roll < yield_pct + 20)
            op = OP_FORK;
        else if (roll < yield_pct + 50)
            op = OP_RETURN;
        else
            op = OP_NEW;
        case ($urandom_range(0, 9))
            0:          prio = 8'h00;
            1:          prio = 8'hFF;
            2, 3, 4:    prio = 8'($urandom_range(0, 3));   // ties
            default:    prio = 8'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 19))
            0:          id = 16'h0000;
            1:          id = 16'hFFFF;
            2, 3:       id = 16'($urandom_range(1, 8));     // likely duplicates
            default:    id = 16'($urandom_range(1, 65535));
        endcase
        return mk_event(op, prio, id);
    endfunction

    task automatic send_item(input t_sched_in ev, input int gap_pct);
        bit taken;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
                i_start <= 1'b0;
            end else begin
                i_start <= 1'b1;
                i_item  <= ev;
                @(posedge i_clk);
                taken = !o_busy;
            end
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
    endtask

    initial begin
        int gap;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: idle yield, idle fork, ties, preemption, refusals
        send_item(mk_event(OP_YIELD,  8'h00, 16'h0000), 0);
        send_item(mk_event(OP_FORK,   8'hFF, 16'hFFFF), 0);
        send_item(mk_event(OP_NEW,    8'h00, 16'h0000), 0);
        send_item(mk_event(OP_NEW,    8'hFF, 16'h0001), 0);
        send_item(mk_event(OP_FORK,   8'h00, 16'h0000), 0);
        send_item(mk_event(OP_RETURN, 8'hFF, 16'h0000), 0);
        send_item(mk_event(OP_RETURN, 8'hFF, 16'hFFFF), 0);
        send_item(mk_event(OP_RETURN, 8'h80, 16'h0003), 0);
        send_item(mk_event(OP_YIELD,  8'hFF, 16'hFFFF), 0);
        for (int i = 0; i < 12; i++) begin
            if (i % 3 == 0)
                send_item(mk_event(OP_RETURN, (i % 2) ? 8'hAA : 8'h55,
                                   (i % 2) ? 16'hAAAA : 16'h5555), 0);
            else
                send_item(mk_event(OP_NEW, (i % 2) ? 8'h55 : 8'hAA, 16'h0000), 0);
        end
        // queue is full now
        send_item(mk_event(OP_NEW,    8'hFF, 16'h0000), 0);
        send_item(mk_event(OP_FORK,   8'h00, 16'h0000), 0);
        send_item(mk_event(OP_RETURN, 8'hFF, 16'h1234), 0);
        send_item(mk_event(OP_YIELD,  8'h00, 16'h0000), 0);
        drain_results();

        // random: light sender gaps, heavy gaps, then back to back
        for (int p = 0; p < 3; p++) begin
            gap = (p == 0) ? 8 : (p == 1) ? 49 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_item(rand_event(n), gap);
                if ($urandom_range(0, 149) == 0)
                    drain_results();
            end
            drain_results();
        end

        for (int n = 0; n < 60; n++)
            send_item(rand_event(n), 8);

        drain_results();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("preemptive_priority_scheduler_core_tb: PASS");
        else
            $display("preemptive_priority_scheduler_core_tb: FAIL");
        $finish;
    end

endmodule
